// File: rtl/ili_pkg.sv
// shared constants and types of the incremental linear interpolator
`timescale 1ns / 1ps

package ili_pkg;

   localparam int COORD_WIDTH_DEF = 16;

   // command codes of the request channel
   localparam logic CMD_INIT = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   // start request from the top level to the serial arithmetic unit
   typedef struct packed {
      logic start;
      logic with_mul;
   } unit_ctl_type;

   // status back from the serial arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

// File: rtl/ili_if.sv
// request and response channel interfaces of the interpolator
`timescale 1ns / 1ps

interface ili_req_if #(
   parameter int COORD_WIDTH = ili_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic signed [COORD_WIDTH-1:0] src_begin;
   logic signed [COORD_WIDTH-1:0] src_current;
   logic signed [COORD_WIDTH-1:0] src_end;
   logic signed [COORD_WIDTH-1:0] dst_begin;
   logic signed [COORD_WIDTH-1:0] dst_end;

   modport source (output valid, cmd, src_begin, src_current, src_end, dst_begin, dst_end,
                   input ready);
   modport sink (input valid, cmd, src_begin, src_current, src_end, dst_begin, dst_end,
                 output ready);
endinterface

interface ili_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] value;
   logic               span_error;

   modport source (output valid, value, span_error, input ready);
   modport sink (input valid, value, span_error, output ready);
endinterface

// File: rtl/ili_serial_unit.sv
// bit-serial shift-add multiplier and restoring divider sharing one shift register
`timescale 1ns / 1ps

module ili_serial_unit #(
   parameter int COORD_WIDTH = ili_pkg::COORD_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ili_pkg::unit_ctl_type        ctl,
   input  logic [COORD_WIDTH:0]         mcand,
   input  logic [COORD_WIDTH-1:0]       mplier,
   input  logic [COORD_WIDTH:0]         dividend_hi,
   input  logic [COORD_WIDTH-1:0]       divisor,
   output ili_pkg::unit_stat_type       stat,
   output logic [2*COORD_WIDTH:0]       quotient,
   output logic [COORD_WIDTH-1:0]       remainder
);

   localparam int CW    = COORD_WIDTH;
   localparam int PW    = 2 * COORD_WIDTH + 1;
   localparam int CNT_W = $clog2(PW);

   localparam logic [CNT_W-1:0] MUL_LAST      = CNT_W'(CW - 1);
   localparam logic [CNT_W-1:0] DIV_FULL_LAST = CNT_W'(PW - 1);
   localparam logic [CNT_W-1:0] DIV_STEP_LAST = CNT_W'(CW);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_MUL  = 2'd1;
   localparam logic [1:0] PH_DIV  = 2'd2;

   logic [1:0]       phase_ff, phase_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [PW-1:0]    work_ff, work_in;
   logic [CW-1:0]    rem_ff, rem_in;
   logic [CW:0]      mcand_ff, mcand_in;

   logic [CW+1:0]    mul_sum;
   logic [PW-1:0]    mul_work;
   logic [CW:0]      trial;
   logic             trial_ge;
   logic [CW:0]      trial_diff;
   logic [CW-1:0]    div_rem;
   logic [PW-1:0]    div_work;

   // multiply: add the multiplicand into the upper half when the low bit is set, shift right
   assign mul_sum  = {1'b0, work_ff[PW-1:CW]} + (work_ff[0] ? {1'b0, mcand_ff} : '0);
   assign mul_work = {mul_sum, work_ff[CW-1:1]};

   // divide: one quotient bit per cycle, quotient shifts in at the bottom
   assign trial      = {rem_ff, work_ff[PW-1]};
   assign trial_ge   = trial >= {1'b0, divisor};
   assign trial_diff = trial - {1'b0, divisor};
   assign div_rem    = trial_ge ? trial_diff[CW-1:0] : trial[CW-1:0];
   assign div_work   = {work_ff[PW-2:0], trial_ge};

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      work_in  = work_ff;
      rem_in   = rem_ff;
      mcand_in = mcand_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (ctl.start) begin
               if (ctl.with_mul) begin
                  work_in  = {{(CW+1){1'b0}}, mplier};
                  mcand_in = mcand;
                  cnt_in   = MUL_LAST;
                  phase_in = PH_MUL;
               end else begin
                  work_in  = {dividend_hi, {CW{1'b0}}};
                  rem_in   = '0;
                  cnt_in   = DIV_STEP_LAST;
                  phase_in = PH_DIV;
               end
            end
         end
         PH_MUL: begin
            work_in = mul_work;
            if (cnt_ff == '0) begin
               rem_in   = '0;
               cnt_in   = DIV_FULL_LAST;
               phase_in = PH_DIV;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         PH_DIV: begin
            work_in = div_work;
            rem_in  = div_rem;
            if (cnt_ff == '0) begin
               phase_in = PH_IDLE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      rem_ff   <= rem_in;
      mcand_ff <= mcand_in;
   end

   assign stat.busy = phase_ff != PH_IDLE;
   assign stat.done = (phase_ff == PH_DIV) && (cnt_ff == '0);
   assign quotient  = work_ff;
   assign remainder = rem_ff;

   a_mul_then_div: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_MUL && cnt_ff == '0) |=> (phase_ff == PH_DIV && cnt_ff == DIV_FULL_LAST))
      else $error("multiply did not hand over to a full-width divide");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DIV) |-> (rem_ff < divisor))
      else $error("partial remainder reached the divisor");

endmodule

// File: rtl/incremental_linear_interpolator.sv
// Incremental linear interpolator: maps a source coordinate range onto a destination range,
// one step per item, with an error accumulator. For an init item (cmd 0) a shift-add
// multiplier forms |offset|*|dest span| one bit per cycle, then a restoring divider
// produces one quotient bit per cycle. A step item (cmd 1) runs the divider only when the
// accumulator holds at least one source span, and otherwise answers without it; a zero source
// span answers with span_error set and the state kept. Both passes share one shift register,
// so one item is worked on at a time; a result register lets the next request transfer while
// the previous response still waits.
`timescale 1ns / 1ps

module incremental_linear_interpolator #(
   parameter int COORD_WIDTH = ili_pkg::COORD_WIDTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   ili_req_if.sink   req,
   ili_rsp_if.source rsp
);

   localparam int CW = COORD_WIDTH;
   localparam int PW = 2 * COORD_WIDTH + 1;
   localparam int QW = (PW > 32) ? PW : 32;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   // control
   logic [1:0]        state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // interpolator state
   logic [31:0]       value_ff, value_in;
   logic              step_neg_ff, step_neg_in;
   logic [CW-1:0]     dspan_ff, dspan_in;
   logic [CW-1:0]     sspan_ff, sspan_in;
   logic signed [CW:0] rem_ff, rem_in;

   // per-item scratch and response payload
   logic [CW-1:0]     db_ff, db_in;
   logic              qneg_ff, qneg_in;
   logic              offneg_ff, offneg_in;
   logic              init_ff, init_in;
   logic              upd_ff, upd_in;
   logic              err_ff, err_in;
   logic [31:0]       rsp_value_ff, rsp_value_in;
   logic              rsp_err_ff, rsp_err_in;

   logic              accept;
   logic [CW:0]       sspan, dspan;
   logic [CW+1:0]     off;
   logic              sneg, dneg, offneg;
   logic [CW:0]       s_mag_full, d_mag_full;
   logic [CW+1:0]     o_mag_full;
   logic              span_zero;
   logic [CW+1:0]     acc;
   logic              acc_big;

   ili_pkg::unit_ctl_type  ctl;
   ili_pkg::unit_stat_type stat;
   logic [PW-1:0]     quotient;
   logic [CW-1:0]     remainder;

   logic [QW-1:0]     q_ext;
   logic [31:0]       q32, base, new_value, fin_value;
   logic [CW:0]       rem_new;
   logic              rsp_load;
   logic [CW:0]       rem_neg;
   logic [CW-1:0]     rem_mag;

   assign accept    = req.valid && req.ready;
   assign req.ready = state_ff == ST_IDLE;

   // range arithmetic for an init transfer
   assign sspan = {req.src_end[CW-1], req.src_end} - {req.src_begin[CW-1], req.src_begin};
   assign dspan = {req.dst_end[CW-1], req.dst_end} - {req.dst_begin[CW-1], req.dst_begin};
   assign off   = {{2{req.src_current[CW-1]}}, req.src_current}
                - {{2{req.src_begin[CW-1]}}, req.src_begin} - (CW+2)'(1);
   assign sneg       = sspan[CW];
   assign dneg       = dspan[CW];
   assign offneg     = off[CW+1];
   assign s_mag_full = sneg ? -sspan : sspan;
   assign d_mag_full = dneg ? -dspan : dspan;
   assign o_mag_full = offneg ? -off : off;
   assign span_zero  = sspan == '0;

   // step: accumulator plus destination span, divided only when a whole span is held
   assign acc     = {rem_ff[CW], rem_ff} + {2'b00, dspan_ff};
   assign acc_big = !acc[CW+1] && (acc[CW:0] >= {1'b0, sspan_ff});

   always_comb begin
      ctl.start    = 1'b0;
      ctl.with_mul = 1'b0;
      if (accept) begin
         if (req.cmd == ili_pkg::CMD_INIT) begin
            ctl.start    = !span_zero;
            ctl.with_mul = 1'b1;
         end else begin
            ctl.start = (sspan_ff != '0) && acc_big;
         end
      end
   end

   ili_serial_unit #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_serial (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .mcand       (o_mag_full[CW:0]),
      .mplier      (d_mag_full[CW-1:0]),
      .dividend_hi (acc[CW:0]),
      .divisor     (sspan_ff),
      .stat        (stat),
      .quotient    (quotient),
      .remainder   (remainder)
   );

   // finishing add: value wraps at 32 bits, quotient keeps its low 32 bits
   assign q_ext     = QW'(quotient);
   assign q32       = q_ext[31:0];
   assign base      = init_ff ? {{(32-CW){db_ff[CW-1]}}, db_ff} : value_ff;
   assign new_value = qneg_ff ? base - q32 : base + q32;
   assign fin_value = upd_ff ? new_value : value_ff;
   assign rem_new   = offneg_ff ? -{1'b0, remainder} : {1'b0, remainder};
   assign rsp_load  = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      step_neg_in  = step_neg_ff;
      dspan_in     = dspan_ff;
      sspan_in     = sspan_ff;
      rem_in       = rem_ff;
      db_in        = db_ff;
      qneg_in      = qneg_ff;
      offneg_in    = offneg_ff;
      init_in      = init_ff;
      upd_in       = upd_ff;
      err_in       = err_ff;
      rsp_value_in = rsp_value_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               err_in    = 1'b0;
               upd_in    = 1'b0;
               init_in   = 1'b0;
               offneg_in = 1'b0;
               state_in  = ST_FIN;
               if (req.cmd == ili_pkg::CMD_INIT) begin
                  if (span_zero) begin
                     err_in = 1'b1;
                  end else begin
                     sspan_in    = s_mag_full[CW-1:0];
                     dspan_in    = d_mag_full[CW-1:0];
                     step_neg_in = dneg ^ sneg;
                     db_in       = req.dst_begin;
                     qneg_in     = offneg ^ dneg ^ sneg;
                     offneg_in   = offneg;
                     init_in     = 1'b1;
                     upd_in      = 1'b1;
                     state_in    = ST_RUN;
                  end
               end else if (sspan_ff == '0) begin
                  err_in = 1'b1;
               end else if (acc_big) begin
                  qneg_in  = step_neg_ff;
                  upd_in   = 1'b1;
                  state_in = ST_RUN;
               end else begin
                  // less than one span held: value stays, accumulator takes the sum
                  rem_in = acc[CW:0];
               end
            end
         end
         ST_RUN: begin
            if (stat.done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (rsp_load) begin
               value_in     = fin_value;
               rsp_value_in = fin_value;
               rsp_err_in   = err_ff;
               rsp_valid_in = 1'b1;
               if (upd_ff) begin
                  rem_in = rem_new;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         value_ff     <= '0;
         step_neg_ff  <= 1'b0;
         dspan_ff     <= '0;
         sspan_ff     <= '0;
         rem_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         value_ff     <= value_in;
         step_neg_ff  <= step_neg_in;
         dspan_ff     <= dspan_in;
         sspan_ff     <= sspan_in;
         rem_ff       <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      db_ff        <= db_in;
      qneg_ff      <= qneg_in;
      offneg_ff    <= offneg_in;
      init_ff      <= init_in;
      upd_ff       <= upd_in;
      err_ff       <= err_in;
      rsp_value_ff <= rsp_value_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.value      = rsp_value_ff;
   assign rsp.span_error = rsp_err_ff;

   // magnitude of the accumulator for the bound check
   assign rem_neg = -rem_ff;
   assign rem_mag = rem_ff[CW] ? rem_neg[CW-1:0] : rem_ff[CW-1:0];

   // an init loads the new span at once but the accumulator only on its result
   a_acc_within_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && sspan_ff != '0) |-> (rem_mag < sspan_ff))
      else $error("accumulator outside the source span");

   a_acc_zero_without_span: assert property (@(posedge clock) disable iff (reset)
      (sspan_ff == '0) |-> (rem_ff == '0))
      else $error("accumulator set while no range is loaded");

   a_run_means_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> stat.busy)
      else $error("waiting on an idle arithmetic unit");

   a_step_without_range: assert property (@(posedge clock) disable iff (reset)
      (accept && req.cmd == ili_pkg::CMD_STEP && sspan_ff == '0)
      |=> (state_ff == ST_FIN && err_ff && !upd_ff))
      else $error("step without a range did not raise the span error");

endmodule

// File: dv/tb.sv
// self-checking testbench of the incremental linear interpolator
`timescale 1ns / 1ps

module tb;

   localparam int CW = ili_pkg::COORD_WIDTH_DEF;
   localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam int RANDOM_ITEMS = 1800;
   localparam int DRAIN_CYCLES = 3*CW + 30;

   typedef struct {
      logic                 cmd;
      logic signed [CW-1:0] src_begin;
      logic signed [CW-1:0] src_current;
      logic signed [CW-1:0] src_end;
      logic signed [CW-1:0] dst_begin;
      logic signed [CW-1:0] dst_end;
   } interp_req_type;

   typedef struct {
      logic [31:0] value;
      logic        span_error;
   } interp_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ili_req_if #(.COORD_WIDTH(CW)) req_ch ();
   ili_rsp_if rsp_ch ();

   incremental_linear_interpolator #(.COORD_WIDTH(CW)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   interp_req_type requests_to_send[$];
   interp_rsp_type predicted_values[$];
   interp_req_type on_bus;
   int          mismatch_count = 0;
   int          sent_count = 0;
   int          rsp_count = 0;
   int          req_gap = 0;
   int          rsp_stall = 0;
   int          hold_left = 0;
   int          hold_mark = 600;

   // predictor state, zero after reset
   logic [31:0] interp_value = '0;
   bit          interp_down = 1'b0;
   longint      dst_mag = 0;
   longint      src_mag = 0;
   longint      interp_acc = 0;

   function automatic interp_rsp_type interp_advance(interp_req_type it);
      interp_rsp_type r;
      longint sb, cur, se, db, de, sspan, dspan, offset, acc, whole;
      sb = it.src_begin;
      cur = it.src_current;
      se = it.src_end;
      db = it.dst_begin;
      de = it.dst_end;
      r.span_error = 1'b0;
      if (it.cmd == ili_pkg::CMD_INIT) begin
         sspan = se - sb;
         dspan = de - db;
         if (sspan == 0) begin
            r.span_error = 1'b1;
         end else begin
            offset = cur - 1 - sb;
            interp_value = 32'(db + (offset * dspan) / sspan);
            interp_down = (de < db) ^ (se < sb);
            dst_mag = (dspan < 0) ? -dspan : dspan;
            src_mag = (sspan < 0) ? -sspan : sspan;
            interp_acc = (offset * dst_mag) % src_mag;
         end
      end else if (src_mag == 0) begin
         r.span_error = 1'b1;
      end else begin
         acc = interp_acc + dst_mag;
         if (acc >= src_mag) begin
            whole = acc / src_mag;
            acc = acc - whole * src_mag;
            if (interp_down)
               interp_value = interp_value - 32'(whole);
            else
               interp_value = interp_value + 32'(whole);
         end
         interp_acc = acc;
      end
      r.value = interp_value;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   function automatic void queue_req(logic cmd, logic signed [CW-1:0] sb,
                                     logic signed [CW-1:0] cur, logic signed [CW-1:0] se,
                                     logic signed [CW-1:0] db, logic signed [CW-1:0] de);
      interp_req_type it;
      it.cmd = cmd;
      it.src_begin = sb;
      it.src_current = cur;
      it.src_end = se;
      it.dst_begin = db;
      it.dst_end = de;
      requests_to_send.push_back(it);
   endfunction

   function automatic logic signed [CW-1:0] rand_coord();
      case ($urandom_range(0, 7))
         0: return COORD_MIN;
         1: return COORD_MAX;
         default: return CW'($urandom);
      endcase
   endfunction

   // range fields carry noise on a step
   function automatic void queue_step();
      queue_req(ili_pkg::CMD_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                rand_coord());
   endfunction

   function automatic int span_draw(int lo);
      case ($urandom_range(0, 3))
         0: return $urandom_range(lo, 4);
         1: return $urandom_range(lo, 64);
         2: return $urandom_range(lo, 4096);
         default: return $urandom_range(lo, 65535);
      endcase
   endfunction

   function automatic int draw_wait(bit calm);
      return calm ? 0 : int'($urandom_range(0, 7));
   endfunction

   // driver: one transfer per accepted item, random gap after each except in calm stretches
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predicted_values.push_back(interp_advance(on_bus));
            sent_count <= sent_count + 1;
            req_gap = draw_wait(((sent_count / 170) % 4) == 2);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (req_gap == 0 && requests_to_send.size() != 0) begin
               on_bus = requests_to_send.pop_front();
               req_ch.cmd <= on_bus.cmd;
               req_ch.src_begin <= on_bus.src_begin;
               req_ch.src_current <= on_bus.src_current;
               req_ch.src_end <= on_bus.src_end;
               req_ch.dst_begin <= on_bus.dst_begin;
               req_ch.dst_end <= on_bus.dst_end;
               req_ch.valid <= 1'b1;
            end else begin
               if (req_gap > 0)
                  req_gap--;
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-offs so the block backs up onto its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (sent_count >= hold_mark) begin
         hold_left <= 400;
         hold_mark <= hold_mark + 800;
      end
   end

   // monitor: check each response transfer against the oldest prediction
   always @(posedge clock) begin
      interp_rsp_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (predicted_values.size() == 0) begin
               report_mismatch($sformatf("response with nothing pending, value %h",
                                         rsp_ch.value));
            end else begin
               want = predicted_values.pop_front();
               if (rsp_ch.value !== want.value)
                  report_mismatch($sformatf("value got %h expected %h",
                                            rsp_ch.value, want.value));
               if (rsp_ch.span_error !== want.span_error)
                  report_mismatch($sformatf("span_error got %b expected %b",
                                            rsp_ch.span_error, want.span_error));
            end
            rsp_count++;
            rsp_stall = draw_wait(((rsp_count / 200) % 4) == 3);
         end else if (rsp_stall > 0) begin
            rsp_stall--;
         end
         rsp_ch.ready <= (rsp_stall == 0) && (hold_left == 0);
      end
   end

   initial begin
      #15_000_000;
      $display("incremental_linear_interpolator verification failed");
      $finish;
   end

   initial begin
      logic signed [CW-1:0] sb, db, se, de, cur;
      int smag, dmag, sdir, ddir, off, seq_len;

      req_ch.valid = 1'b0;
      req_ch.cmd = ili_pkg::CMD_INIT;
      req_ch.src_begin = '0;
      req_ch.src_current = '0;
      req_ch.src_end = '0;
      req_ch.dst_begin = '0;
      req_ch.dst_end = '0;
      rsp_ch.ready = 1'b0;

      // step before any init, then a zero source span
      queue_step();
      queue_req(ili_pkg::CMD_INIT, 16'sd100, 16'sd5, 16'sd100, 16'sd7, -16'sd9);
      // full ranges, starting at the beginning
      queue_req(ili_pkg::CMD_INIT, COORD_MIN, COORD_MIN + 1, COORD_MAX, COORD_MIN,
                COORD_MAX);
      queue_step();
      queue_step();
      // unit source span with a huge offset: initial value wraps
      queue_req(ili_pkg::CMD_INIT, COORD_MIN, COORD_MAX, COORD_MIN + 1, COORD_MIN,
                COORD_MAX);
      queue_step();
      queue_step();
      // both ranges reversed
      queue_req(ili_pkg::CMD_INIT, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN);
      queue_step();
      queue_step();
      // the first step lands the value just below the signed limit, the second step wraps it
      queue_req(ili_pkg::CMD_INIT, COORD_MIN, 16'sd1, COORD_MIN + 1, COORD_MIN, COORD_MAX);
      queue_step();
      queue_step();
      // stepping downwards
      queue_req(ili_pkg::CMD_INIT, 16'sd0, 16'sd1, 16'sd10, 16'sd100, -16'sd5);
      queue_step();
      queue_step();
      queue_step();
      // source position well outside the range, negative remainder
      queue_req(ili_pkg::CMD_INIT, 16'sd0, -16'sd1000, 16'sd3, 16'sd0, 16'sd7);
      queue_step();
      queue_step();
      queue_step();
      // zero span after a valid init keeps the state
      queue_req(ili_pkg::CMD_INIT, -16'sd42, 16'sd3, -16'sd42, COORD_MAX, COORD_MIN);
      queue_step();

      seq_len = requests_to_send.size() + RANDOM_ITEMS;
      while (requests_to_send.size() < seq_len) begin
         case ($urandom_range(0, 9))
            0: begin
               queue_req($urandom_range(0, 1) ? ili_pkg::CMD_STEP : ili_pkg::CMD_INIT,
                         rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                         rand_coord());
            end
            1: begin
               sb = rand_coord();
               queue_req(ili_pkg::CMD_INIT, sb, rand_coord(), sb, rand_coord(),
                         rand_coord());
               queue_step();
            end
            default: begin
               sb = rand_coord();
               db = rand_coord();
               smag = span_draw(1);
               dmag = span_draw(0);
               sdir = $urandom_range(0, 1) ? -1 : 1;
               ddir = $urandom_range(0, 1) ? -1 : 1;
               se = CW'(int'(sb) + sdir * smag);
               de = CW'(int'(db) + ddir * dmag);
               if ($urandom_range(0, 4) != 0) begin
                  off = $urandom_range(0, smag);
                  cur = CW'(int'(sb) + 1 + sdir * off);
               end else begin
                  cur = rand_coord();
               end
               queue_req(ili_pkg::CMD_INIT, sb, cur, se, db, de);
               off = $urandom_range(1, 40);
               repeat (off) queue_step();
            end
         endcase
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (requests_to_send.size() != 0 || req_ch.valid)
         @(posedge clock);
      while (predicted_values.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("incremental_linear_interpolator verification clean");
      else
         $display("incremental_linear_interpolator verification failed");
      $finish;
   end

endmodule
